// ===== rtl/wsrm_pkg.sv =====
`default_nettype none

package wsrm_pkg;

    localparam int MAX_TOKENS = 16;
    localparam int LEN_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 8;

    // '.' accepts any byte
    localparam logic [CHAR_W-1:0] DOT_BYTE = 8'd46;

    // register indexes on the configuration port
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TEXT  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    // carries handed from one cell to the next
    typedef struct packed {
        logic pre;   // closure of the held active bits
        logic adv;   // token consumed, position moves up
        logic post;  // closure of the new active bits
    } link_t;

    // per-cell control from the top level
    typedef struct packed {
        logic load_tok;
        logic load_act;
        logic start;
        logic in_use;
        logic pos_ok;
        logic first;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/wsrm_cell.sv =====
`default_nettype none

module wsrm_cell (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire wsrm_pkg::cell_ctl_t   ctl,
    input  wire [wsrm_pkg::CHAR_W-1:0] token_char,
    input  wire                        token_star,
    input  wire [wsrm_pkg::CHAR_W-1:0] text_char,
    input  wire wsrm_pkg::link_t       link_in,
    output wsrm_pkg::link_t            link_out,
    output logic                       active_out
);

    logic [wsrm_pkg::CHAR_W-1:0] tok_reg;
    logic                        star_reg;
    logic                        act_reg;
    logic                        act_next;

    logic pre;
    logic accept_byte;
    logic fire;
    logic raw;

    always_comb begin
        pre         = (act_reg | link_in.pre) & ctl.pos_ok;
        accept_byte = (tok_reg == wsrm_pkg::DOT_BYTE) || (tok_reg == text_char);
        fire        = pre & accept_byte & ctl.in_use;
        // a start item restarts the chain at position zero
        raw         = ctl.start ? ctl.first : ((fire & star_reg) | link_in.adv);
        act_next    = (raw | link_in.post) & ctl.pos_ok;

        link_out.pre  = pre & star_reg & ctl.in_use;
        link_out.adv  = ~ctl.start & fire & ~star_reg;
        link_out.post = act_next & star_reg & ctl.in_use;
        active_out    = act_next;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_tok) begin
            tok_reg  <= token_char;
            star_reg <= token_star;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ctl.first;
        end else if (ctl.load_act) begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wildcard_star_regex_matcher_top.sv =====
`default_nettype none

// whole-string matcher for patterns of literal bytes, '.' and '*' repeats
//
// input channel (s_valid/s_ready): one item per op
//   load   - writes token s_token_index (byte s_token_char, repeat flag s_token_star)
//   start  - begins a new text and reports whether the empty text matches
//   text   - feeds byte s_text_char and reports whether the text so far matches
//   no-op  - changes nothing
// result channel (m_valid/m_ready): exactly one item per input item, m_matched
//   is 0 for load and no-op items
// pattern_length is written over the apb port while no item is in flight
//
// result: registered, and shown in the cycle after the item is taken
// throughput: one item per cycle unless the output stalls; the whole active-bit
//   update is one combinational ripple along the row of 16 token cells
// stalls: the output register holds its item while m_ready is low and
//   s_ready drops only then; when m_ready is high a new item enters each cycle
// reset: pattern_length 0, only position zero active, no result pending;
//   token contents are unknown until loaded

module wildcard_star_regex_matcher_top (
    input  wire                        aclk,
    input  wire                        aresetn,
    // configuration
    input  wire                        psel,
    input  wire                        penable,
    input  wire                        pwrite,
    input  wire                        paddr,
    input  wire [31:0]                 pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input items
    input  wire                        s_valid,
    output logic                       s_ready,
    input  wire [1:0]                  s_op,
    input  wire [wsrm_pkg::IDX_W-1:0]  s_token_index,
    input  wire [wsrm_pkg::CHAR_W-1:0] s_token_char,
    input  wire                        s_token_star,
    input  wire [wsrm_pkg::CHAR_W-1:0] s_text_char,
    // result items
    output logic                       m_valid,
    input  wire                        m_ready,
    output logic                       m_matched
);

    localparam int N = wsrm_pkg::MAX_TOKENS;

    logic [wsrm_pkg::LEN_W-1:0] plen_reg;
    logic [wsrm_pkg::LEN_W-1:0] used_len;

    logic m_valid_reg;
    logic m_valid_next;
    logic m_matched_reg;
    logic m_matched_next;

    // extra position past the last token: the whole pattern consumed
    logic tail_raw;
    logic tail_next;
    logic tail_ok;

    wsrm_pkg::op_t   op;
    logic            accept;
    logic            do_load;
    logic            do_start;
    logic            do_text;

    wsrm_pkg::link_t     link [N+1];
    wsrm_pkg::cell_ctl_t ctl  [N];
    logic [N:0]          active_vec;

    // ---------------- configuration port ----------------

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr == wsrm_pkg::REG_PATTERN_LENGTH) begin
            prdata = {{(32 - wsrm_pkg::LEN_W){1'b0}}, plen_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && (paddr == wsrm_pkg::REG_PATTERN_LENGTH)) begin
            plen_reg <= pwdata[wsrm_pkg::LEN_W-1:0];
        end
    end

    // lengths past the number of cells saturate
    assign used_len = (plen_reg > wsrm_pkg::LEN_W'(N)) ? wsrm_pkg::LEN_W'(N) : plen_reg;

    // ---------------- op decode ----------------

    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign op      = wsrm_pkg::op_t'(s_op);

    always_comb begin
        do_load  = 1'b0;
        do_start = 1'b0;
        do_text  = 1'b0;
        unique case (op)
            wsrm_pkg::OP_LOAD:  do_load  = accept;
            wsrm_pkg::OP_START: do_start = accept;
            wsrm_pkg::OP_TEXT:  do_text  = accept;
            default: ;
        endcase
    end

    // ---------------- row of token cells ----------------

    assign link[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        always_comb begin
            ctl[i].load_tok = do_load & (s_token_index == wsrm_pkg::IDX_W'(i));
            ctl[i].load_act = do_start | do_text;
            ctl[i].start    = (op == wsrm_pkg::OP_START);
            ctl[i].in_use   = (wsrm_pkg::LEN_W'(i) < used_len);
            ctl[i].pos_ok   = (wsrm_pkg::LEN_W'(i) <= used_len);
            ctl[i].first    = (i == 0);
        end

        wsrm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl[i]),
            .token_char (s_token_char),
            .token_star (s_token_star),
            .text_char  (s_text_char),
            .link_in    (link[i]),
            .link_out   (link[i+1]),
            .active_out (active_vec[i])
        );
    end

    // final position only exists when every token is in use; its bit is not held
    // in a register, as no token sits there to read it
    always_comb begin
        tail_ok   = (used_len == wsrm_pkg::LEN_W'(N));
        tail_raw  = (op == wsrm_pkg::OP_START) ? 1'b0 : link[N].adv;
        tail_next = (tail_raw | link[N].post) & tail_ok;
    end

    assign active_vec[N] = tail_next;

    // ---------------- result register ----------------

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_matched_next = m_matched_reg;
        if (accept) begin
            m_valid_next   = 1'b1;
            // whole pattern consumed after closure
            m_matched_next = (do_start | do_text) & active_vec[used_len];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg <= m_matched_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

`default_nettype wire
